[rtl/core/tqp_pkg.sv]
// ----------------------------------------------------------------------------
// tqp_pkg
// shared constants for the two queue priority task picker
// ----------------------------------------------------------------------------
`default_nettype none
package tqp_pkg;
    localparam int QUEUE_DEPTH   = 16;
    localparam int TASK_ID_BITS  = 8;
    localparam int PRIORITY_BITS = 8;

    localparam int ENTRY_W = TASK_ID_BITS + PRIORITY_BITS;
    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_WAKE    = 2'd0;
    localparam logic [1:0] MODE_PICK    = 2'd1;
    localparam logic [1:0] MODE_REQUEUE = 2'd2;

    localparam logic [1:0] Q_MAIN = 2'd0;
    localparam logic [1:0] Q_GEN  = 2'd1;
    localparam logic [1:0] Q_PIN  = 2'd2;
    localparam int NUM_Q = 3;

    typedef logic [CNT_W-1:0] cnt_t;
endpackage
`default_nettype wire

[rtl/core/tqp_ram.sv]
// ----------------------------------------------------------------------------
// tqp_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module tqp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/two_queue_priority_task_picker.sv]
// ----------------------------------------------------------------------------
// two_queue_priority_task_picker
// three ready queues (main sorted, general sorted, pinned fifo) held in rams
// ----------------------------------------------------------------------------
// channel  ports                                               direction
// s_       s_valid s_ready s_mode s_task_id s_priority_req     in
//          s_run_on_main s_pinned s_from_main_thread
// m_       m_valid m_ready m_task_valid m_picked_task          out
//          m_any_ready m_dropped
//
// one request at a time; a queue is walked entry by entry by a
// single read-modify-write sequencer on the selected queue ram.
// reset empties all queues at once through the count registers.
// a new request is taken while the previous result waits on m_ready.
// ----------------------------------------------------------------------------
`default_nettype none
module two_queue_priority_task_picker
    import tqp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic [7:0] s_task_id,
    input  wire logic [7:0] s_priority_req,
    input  wire logic       s_run_on_main,
    input  wire logic       s_pinned,
    input  wire logic       s_from_main_thread,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_task_valid,
    output logic [7:0]      m_picked_task,
    output logic            m_any_ready,
    output logic            m_dropped
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_PICK_RD  = 4'd2;
    localparam logic [3:0] S_SRCH     = 4'd3;
    localparam logic [3:0] S_SRCH_CMP = 4'd4;
    localparam logic [3:0] S_SHD      = 4'd5;
    localparam logic [3:0] S_SHD_WR   = 4'd6;
    localparam logic [3:0] S_INS      = 4'd7;
    localparam logic [3:0] S_INS_SCAN = 4'd8;
    localparam logic [3:0] S_INS_CMP  = 4'd9;
    localparam logic [3:0] S_SHU      = 4'd10;
    localparam logic [3:0] S_SHU_WR   = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] q_reg, q_next;
    cnt_t       idx_reg, idx_next;
    cnt_t       pos_reg, pos_next;
    cnt_t       cnt_reg [NUM_Q];
    cnt_t       cnt_next [NUM_Q];

    logic [1:0]               mode_reg, mode_next;
    logic [TASK_ID_BITS-1:0]  id_reg, id_next;
    logic [PRIORITY_BITS-1:0] pri_reg, pri_next;
    logic                     main_reg, main_next;
    logic                     pin_reg, pin_next;
    logic                     from_reg, from_next;

    logic                    res_valid_reg, res_valid_next;
    logic [TASK_ID_BITS-1:0] res_task_reg, res_task_next;
    logic                    res_drop_reg, res_drop_next;

    logic       m_valid_reg, m_valid_next;
    logic       m_tv_reg, m_tv_next;
    logic [7:0] m_pt_reg, m_pt_next;
    logic       m_ar_reg, m_ar_next;
    logic       m_dr_reg, m_dr_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata [NUM_Q];

    logic [ENTRY_W-1:0]       rd_data;
    logic [TASK_ID_BITS-1:0]  rd_id;
    logic [PRIORITY_BITS-1:0] rd_pri;
    cnt_t                     cnt_q;
    logic [1:0]               tgt;

    for (genvar g = 0; g < NUM_Q; g++) begin : g_ram
        tqp_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
            .aclk  (aclk),
            .we    (ram_we && (q_reg == 2'(g))),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .raddr (ram_raddr),
            .rdata (ram_rdata[g])
        );
    end

    always_comb begin
        case (q_reg)
            Q_MAIN:  rd_data = ram_rdata[0];
            Q_GEN:   rd_data = ram_rdata[1];
            Q_PIN:   rd_data = ram_rdata[2];
            default: rd_data = ram_rdata[0];
        endcase
        case (q_reg)
            Q_MAIN:  cnt_q = cnt_reg[0];
            Q_GEN:   cnt_q = cnt_reg[1];
            Q_PIN:   cnt_q = cnt_reg[2];
            default: cnt_q = cnt_reg[0];
        endcase
    end

    assign rd_id  = rd_data[ENTRY_W-1:PRIORITY_BITS];
    assign rd_pri = rd_data[PRIORITY_BITS-1:0];
    assign tgt    = pin_reg ? Q_PIN : (main_reg ? Q_MAIN : Q_GEN);

    always_comb begin
        state_next     = state_reg;
        q_next         = q_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        for (int k = 0; k < NUM_Q; k++) begin
            cnt_next[k] = cnt_reg[k];
        end
        mode_next      = mode_reg;
        id_next        = id_reg;
        pri_next       = pri_reg;
        main_next      = main_reg;
        pin_next       = pin_reg;
        from_next      = from_reg;
        res_valid_next = res_valid_reg;
        res_task_next  = res_task_reg;
        res_drop_next  = res_drop_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_tv_next      = m_tv_reg;
        m_pt_next      = m_pt_reg;
        m_ar_next      = m_ar_reg;
        m_dr_next      = m_dr_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        s_ready        = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next      = s_mode;
                    id_next        = s_task_id[TASK_ID_BITS-1:0];
                    pri_next       = s_priority_req[PRIORITY_BITS-1:0];
                    main_next      = s_run_on_main;
                    pin_next       = s_pinned;
                    from_next      = s_from_main_thread;
                    res_valid_next = 1'b0;
                    res_task_next  = '0;
                    res_drop_next  = 1'b0;
                    state_next     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (mode_reg)
                    MODE_WAKE: state_next = S_INS;
                    MODE_PICK: begin
                        if (from_reg && cnt_reg[0] != '0) begin
                            q_next     = Q_MAIN;
                            state_next = S_PICK_RD;
                        end else if (cnt_reg[1] != '0) begin
                            q_next     = Q_GEN;
                            state_next = S_PICK_RD;
                        end else if (cnt_reg[2] != '0) begin
                            q_next     = Q_PIN;
                            state_next = S_PICK_RD;
                        end else begin
                            state_next = S_FIN;
                        end
                    end
                    MODE_REQUEUE: begin
                        q_next     = Q_MAIN;
                        idx_next   = '0;
                        state_next = S_SRCH;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_PICK_RD: begin
                ram_raddr  = '0;
                state_next = S_SRCH_CMP;
                // reuse compare state: match forced by pick mode
            end
            S_SRCH: begin
                if (idx_reg >= cnt_q) begin
                    idx_next = '0;
                    case (q_reg)
                        Q_MAIN:  q_next = Q_GEN;
                        Q_GEN:   q_next = Q_PIN;
                        default: state_next = S_FIN;
                    endcase
                end else begin
                    ram_raddr  = idx_reg[ADDR_W-1:0];
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (mode_reg == MODE_PICK) begin
                    res_valid_next = 1'b1;
                    res_task_next  = rd_id;
                    pos_next       = '0;
                    state_next     = S_SHD;
                end else if (rd_id == id_reg) begin
                    pos_next   = idx_reg;
                    state_next = S_SHD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_SHD: begin
                if (CNT_W'(pos_reg + 1'b1) < cnt_q) begin
                    ram_raddr  = ADDR_W'(pos_reg + 1'b1);
                    state_next = S_SHD_WR;
                end else begin
                    cnt_next[q_reg] = cnt_q - 1'b1;
                    state_next      = (mode_reg == MODE_PICK) ? S_FIN : S_INS;
                end
            end
            S_SHD_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[ADDR_W-1:0];
                ram_wdata  = rd_data;
                pos_next   = pos_reg + 1'b1;
                state_next = S_SHD;
            end
            S_INS: begin
                q_next = tgt;
                if (cnt_reg[tgt] == CNT_W'(QUEUE_DEPTH)) begin
                    res_drop_next = 1'b1;
                    state_next    = S_FIN;
                end else if (pin_reg) begin
                    pos_next   = cnt_reg[tgt];
                    idx_next   = cnt_reg[tgt];
                    state_next = S_SHU;
                end else begin
                    idx_next   = '0;
                    state_next = S_INS_SCAN;
                end
            end
            S_INS_SCAN: begin
                if (idx_reg >= cnt_q) begin
                    pos_next   = idx_reg;
                    state_next = S_SHU;
                end else begin
                    ram_raddr  = idx_reg[ADDR_W-1:0];
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (rd_pri >= pri_reg) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_INS_SCAN;
                end else begin
                    pos_next   = idx_reg;
                    idx_next   = cnt_q;
                    state_next = S_SHU;
                end
            end
            S_SHU: begin
                if (idx_reg > pos_reg) begin
                    ram_raddr  = ADDR_W'(idx_reg - 1'b1);
                    state_next = S_SHU_WR;
                end else begin
                    ram_we          = 1'b1;
                    ram_waddr       = pos_reg[ADDR_W-1:0];
                    ram_wdata       = {id_reg, pin_reg ? PRIORITY_BITS'(0) : pri_reg};
                    cnt_next[q_reg] = cnt_q + 1'b1;
                    state_next      = S_FIN;
                end
            end
            S_SHU_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[ADDR_W-1:0];
                ram_wdata  = rd_data;
                idx_next   = idx_reg - 1'b1;
                state_next = S_SHU;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_tv_next    = res_valid_reg;
                    m_pt_next    = 8'(res_task_reg);
                    m_ar_next    = (cnt_reg[0] != '0) || (cnt_reg[1] != '0) ||
                                   (cnt_reg[2] != '0);
                    m_dr_next    = res_drop_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_Q; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int k = 0; k < NUM_Q; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
        q_reg         <= q_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        mode_reg      <= mode_next;
        id_reg        <= id_next;
        pri_reg       <= pri_next;
        main_reg      <= main_next;
        pin_reg       <= pin_next;
        from_reg      <= from_next;
        res_valid_reg <= res_valid_next;
        res_task_reg  <= res_task_next;
        res_drop_reg  <= res_drop_next;
        m_tv_reg      <= m_tv_next;
        m_pt_reg      <= m_pt_next;
        m_ar_reg      <= m_ar_next;
        m_dr_reg      <= m_dr_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_task_valid  = m_tv_reg;
    assign m_picked_task = m_pt_reg;
    assign m_any_ready   = m_ar_reg;
    assign m_dropped     = m_dr_reg;
endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives wake, pick, requeue and invalid-mode requests into the task picker under several
// idle/stall phases and checks every result against a queue-level predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tqp_pkg::*;

    typedef struct packed {
        logic       task_valid;
        logic [7:0] picked_task;
        logic       any_ready;
        logic       dropped;
    } pick_result_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] pri;
    } entry_t;

    // ready-queue model and pending result store
    class picker_scoreboard;
        entry_t       main_q[$];
        entry_t       gen_q[$];
        entry_t       pin_q[$];
        pick_result_t pending[$];
        int           errors;
        int           checked;
        int           drops;
        int           picks_hit;

        function bit place_task(logic [7:0] id, logic [7:0] pri, logic on_main,
                                logic pin);
            entry_t e;
            int     pos;
            e.id  = id;
            e.pri = pin ? 8'd0 : pri;
            if (pin) begin
                if (pin_q.size() >= QUEUE_DEPTH) return 1'b1;
                pin_q.insert(pin_q.size(), e);
            end else if (on_main) begin
                if (main_q.size() >= QUEUE_DEPTH) return 1'b1;
                pos = 0;
                while (pos < main_q.size() && main_q[pos].pri >= pri) pos++;
                main_q.insert(pos, e);
            end else begin
                if (gen_q.size() >= QUEUE_DEPTH) return 1'b1;
                pos = 0;
                while (pos < gen_q.size() && gen_q[pos].pri >= pri) pos++;
                gen_q.insert(pos, e);
            end
            return 1'b0;
        endfunction

        function bit unlink_task(logic [7:0] id);
            foreach (main_q[i]) if (main_q[i].id == id) begin
                main_q.delete(i);
                return 1'b1;
            end
            foreach (gen_q[i]) if (gen_q[i].id == id) begin
                gen_q.delete(i);
                return 1'b1;
            end
            foreach (pin_q[i]) if (pin_q[i].id == id) begin
                pin_q.delete(i);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(logic [1:0] mode, logic [7:0] id, logic [7:0] pri,
                                   logic on_main, logic pin, logic from_main);
            pick_result_t r;
            entry_t       e;
            r = '0;
            if (mode == MODE_WAKE) begin
                r.dropped = place_task(id, pri, on_main, pin);
            end else if (mode == MODE_PICK) begin
                if (from_main && main_q.size() > 0) begin
                    e = main_q[0];
                    main_q.delete(0);
                    r.task_valid = 1'b1;
                end else if (gen_q.size() > 0) begin
                    e = gen_q[0];
                    gen_q.delete(0);
                    r.task_valid = 1'b1;
                end else if (pin_q.size() > 0) begin
                    e = pin_q[0];
                    pin_q.delete(0);
                    r.task_valid = 1'b1;
                end
                if (r.task_valid) r.picked_task = e.id;
            end else if (mode == MODE_REQUEUE) begin
                if (unlink_task(id)) r.dropped = place_task(id, pri, on_main, pin);
            end
            r.any_ready = (main_q.size() + gen_q.size() + pin_q.size()) > 0;
            if (r.dropped) drops++;
            if (r.task_valid) picks_hit++;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(pick_result_t got);
            pick_result_t exp;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("result with no request waiting", 0, 0);
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got.task_valid !== exp.task_valid)
                report_mismatch("task_valid", got.task_valid, exp.task_valid);
            if (got.picked_task !== exp.picked_task)
                report_mismatch("picked_task", got.picked_task, exp.picked_task);
            if (got.any_ready !== exp.any_ready)
                report_mismatch("any_ready", got.any_ready, exp.any_ready);
            if (got.dropped !== exp.dropped)
                report_mismatch("dropped", got.dropped, exp.dropped);
        endfunction

        function void report_mismatch(string what, int got, int exp);
            errors++;
            if (errors <= 30)
                $display("MISMATCH result %0d %s: got %0d expected %0d",
                         checked, what, got, exp);
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [7:0] s_task_id;
    logic [7:0] s_priority_req;
    logic       s_run_on_main;
    logic       s_pinned;
    logic       s_from_main_thread;
    logic       m_valid;
    logic       m_ready;
    logic       m_task_valid;
    logic [7:0] m_picked_task;
    logic       m_any_ready;
    logic       m_dropped;

    picker_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    longint cycles = 0;
    int  sent;

    two_queue_priority_task_picker u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_task_id(s_task_id), .s_priority_req(s_priority_req),
        .s_run_on_main(s_run_on_main), .s_pinned(s_pinned),
        .s_from_main_thread(s_from_main_thread),
        .m_valid(m_valid), .m_ready(m_ready), .m_task_valid(m_task_valid),
        .m_picked_task(m_picked_task), .m_any_ready(m_any_ready),
        .m_dropped(m_dropped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: sample at rising edge, stall at falling edge
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_task_valid, m_picked_task, m_any_ready, m_dropped});
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (cycles > 1000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] mode, logic [7:0] id, logic [7:0] pri,
                                logic on_main, logic pin, logic from_main);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_mode             <= mode;
        s_task_id          <= id;
        s_priority_req     <= pri;
        s_run_on_main      <= on_main;
        s_pinned           <= pin;
        s_from_main_thread <= from_main;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(mode, id, pri, on_main, pin, from_main);
        sent++;
        @(negedge aclk);
    endtask

    // mostly ids from a small pool so requeues find their task
    task automatic send_random;
        int         sel;
        logic [1:0] mode;
        logic [7:0] id;
        sel = $urandom_range(99);
        if (sel < 42) mode = MODE_WAKE;
        else if (sel < 80) mode = MODE_PICK;
        else if (sel < 97) mode = MODE_REQUEUE;
        else mode = 2'd3;
        id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        send_request(mode, id,
                     ($urandom_range(2) == 0) ? 8'($urandom_range(3)) : 8'($urandom),
                     1'($urandom_range(1)), ($urandom_range(3) == 0),
                     1'($urandom_range(1)));
    endtask

    task automatic wait_drained;
        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_WAKE;
        s_task_id = '0;
        s_priority_req = '0;
        s_run_on_main = 1'b0;
        s_pinned = 1'b0;
        s_from_main_thread = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty pick, extremes, sort order, requeue cases, invalid mode, gen queue overflow
        send_request(MODE_PICK, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
        send_request(MODE_REQUEUE, 8'd9, 8'd1, 1'b0, 1'b0, 1'b0);
        send_request(MODE_WAKE, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
        send_request(MODE_WAKE, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_request(MODE_WAKE, 8'd1, 8'd255, 1'b0, 1'b0, 1'b0);
        send_request(MODE_WAKE, 8'd2, 8'd7, 1'b1, 1'b0, 1'b0);
        send_request(MODE_WAKE, 8'd3, 8'd9, 1'b1, 1'b0, 1'b0);
        send_request(MODE_WAKE, 8'd4, 8'd0, 1'b1, 1'b1, 1'b0);
        send_request(MODE_WAKE, 8'd4, 8'd3, 1'b0, 1'b1, 1'b0);
        send_request(2'd3, 8'd170, 8'd85, 1'b1, 1'b1, 1'b1);
        send_request(MODE_PICK, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_request(MODE_PICK, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
        send_request(MODE_REQUEUE, 8'd4, 8'd200, 1'b1, 1'b0, 1'b0);
        send_request(MODE_REQUEUE, 8'd1, 8'd100, 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < 17; i++)
            send_request(MODE_WAKE, 8'(i + 32), 8'(i % 3), 1'b0, 1'b0, 1'b0);
        send_request(MODE_REQUEUE, 8'd32, 8'd5, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 22; i++)
            send_request(MODE_PICK, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 18 : 51) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 18 : 51) : 0;
            for (int i = 0; i < 190; i++) send_random();
        end
        s_valid        <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();

        $display("sent %0d requests, checked %0d results: %0d tasks picked, %0d drops",
                 sent, sb.checked, sb.picks_hit, sb.drops);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
